FILE: rtl/core/dvst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dvst_pkg
// Shared constants and codes for the distinct value set table.
// ----------------------------------------------------------------------------
package dvst_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_REMOVE  = 2'd1,
    KIND_REPLACE = 2'd2,
    KIND_LOOKUP  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_PRESENT     = 3'd1,
    ST_NOT_FOUND   = 3'd2,
    ST_FULL        = 3'd3,
    ST_NEW_PRESENT = 3'd4
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/core/distinct_value_set_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// distinct_value_set_table_top
// Table of up to CAPACITY distinct signed 32-bit values with insert, remove,
// replace and lookup requests, one result (success, status) per request.
//
// Channels: in_* carries a request (kind, value, new_value) under
// in_valid/in_ready; out_* carries the result (success, status) under
// out_valid/out_ready. A transaction happens when valid and ready are high.
// Values live in a synchronous RAM with a registered read port;
// valid marks are flip-flops.
// A request is scanned one slot per cycle through the RAM read port; the
// write-back state (S_EXEC) then updates the table and registers the result.
// A new request is taken only while no request is being processed; a result
// waiting in the output register does not block acceptance. If the receiver
// stalls, the write-back cycle waits until the output register is free.
// Reset (rst_n low, synchronous) clears all valid marks, empties the output
// register and returns to idle; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module distinct_value_set_table_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_kind,
  input  wire logic signed [31:0] in_value,
  input  wire logic signed [31:0] in_new_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_success,
  output logic [2:0]              out_status
);

  localparam int IW = dvst_pkg::IDX_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(dvst_pkg::CAPACITY - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_t;

  state_t              state_r;
  logic [31:0]         mem [dvst_pkg::CAPACITY];
  logic [dvst_pkg::CAPACITY-1:0] valid_r;

  dvst_pkg::kind_t     kind_r;
  logic [31:0]         value_r;
  logic [31:0]         new_value_r;

  logic [IW-1:0]       issue_idx_r;
  logic                issue_done_r;
  logic                rd_pend_r;
  logic [IW-1:0]       rd_idx_r;
  logic [31:0]         rd_data_r;

  logic                hit_found_r;
  logic [IW-1:0]       hit_idx_r;
  logic                nv_found_r;
  logic                free_found_r;
  logic [IW-1:0]       free_idx_r;

  logic                out_valid_r;
  logic                out_success_r;
  dvst_pkg::status_t   out_status_r;

  logic                in_accept;
  logic                rd_en;
  logic                slot_vld;
  logic                hit_now;
  logic                nv_now;
  logic                free_now;
  logic                out_free;
  logic                exec_go;

  logic                wr_en;
  logic [IW-1:0]       wr_idx;
  logic [31:0]         wr_data;
  logic                vset_en;
  logic                vclr_en;
  logic                res_success;
  dvst_pkg::status_t   res_status;

  assign in_ready    = (state_r == S_IDLE);
  assign in_accept   = in_valid && in_ready;
  assign out_valid   = out_valid_r;
  assign out_success = out_success_r;
  assign out_status  = out_status_r;

  assign rd_en    = (state_r == S_SCAN) && !issue_done_r;
  assign slot_vld = valid_r[rd_idx_r];
  assign hit_now  = rd_pend_r && slot_vld && (rd_data_r == value_r);
  assign nv_now   = rd_pend_r && slot_vld && (rd_data_r == new_value_r);
  assign free_now = rd_pend_r && !slot_vld;
  assign out_free = !out_valid_r || out_ready;
  assign exec_go  = (state_r == S_EXEC) && out_free;

  // decision after the full scan
  always_comb begin
    wr_en       = 1'b0;
    wr_idx      = hit_idx_r;
    wr_data     = new_value_r;
    vset_en     = 1'b0;
    vclr_en     = 1'b0;
    res_success = 1'b0;
    res_status  = dvst_pkg::ST_NOT_FOUND;
    unique case (kind_r)
      dvst_pkg::KIND_INSERT: begin
        if (hit_found_r) begin
          res_status = dvst_pkg::ST_PRESENT;
        end else if (!free_found_r) begin
          res_status = dvst_pkg::ST_FULL;
        end else begin
          wr_en       = exec_go;
          wr_idx      = free_idx_r;
          wr_data     = value_r;
          vset_en     = exec_go;
          res_success = 1'b1;
          res_status  = dvst_pkg::ST_OK;
        end
      end
      dvst_pkg::KIND_REMOVE: begin
        if (hit_found_r) begin
          vclr_en     = exec_go;
          res_success = 1'b1;
          res_status  = dvst_pkg::ST_OK;
        end
      end
      dvst_pkg::KIND_REPLACE: begin
        if (hit_found_r) begin
          if (nv_found_r) begin
            res_status = dvst_pkg::ST_NEW_PRESENT;
          end else begin
            wr_en       = exec_go;
            res_success = 1'b1;
            res_status  = dvst_pkg::ST_OK;
          end
        end
      end
      dvst_pkg::KIND_LOOKUP: begin
        if (hit_found_r) begin
          res_success = 1'b1;
          res_status  = dvst_pkg::ST_OK;
        end
      end
      default: begin
        res_status = dvst_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // value RAM
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[issue_idx_r];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r      <= dvst_pkg::kind_t'(in_kind);
      value_r     <= in_value;
      new_value_r <= in_new_value;
    end
    if (rd_en) begin
      rd_idx_r <= issue_idx_r;
    end
    if (hit_now && !hit_found_r) begin
      hit_idx_r <= rd_idx_r;
    end
    if (free_now && !free_found_r) begin
      free_idx_r <= rd_idx_r;
    end
    if (exec_go) begin
      out_success_r <= res_success;
      out_status_r  <= res_status;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      issue_idx_r  <= '0;
      issue_done_r <= 1'b0;
      rd_pend_r    <= 1'b0;
      hit_found_r  <= 1'b0;
      nv_found_r   <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_pend_r <= rd_en;
      if (out_valid_r && out_ready && !exec_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            state_r      <= S_SCAN;
            issue_idx_r  <= '0;
            issue_done_r <= 1'b0;
            hit_found_r  <= 1'b0;
            nv_found_r   <= 1'b0;
            free_found_r <= 1'b0;
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            if (issue_idx_r == LAST_IDX) begin
              issue_done_r <= 1'b1;
            end else begin
              issue_idx_r <= issue_idx_r + 1'b1;
            end
          end
          if (hit_now) begin
            hit_found_r <= 1'b1;
          end
          if (nv_now) begin
            nv_found_r <= 1'b1;
          end
          if (free_now) begin
            free_found_r <= 1'b1;
          end
          if (rd_pend_r && (rd_idx_r == LAST_IDX)) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (vset_en) begin
              valid_r[wr_idx] <= 1'b1;
            end
            if (vclr_en) begin
              valid_r[hit_idx_r] <= 1'b0;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !rd_en)
    else $error("RAM read issued while idle");

  a_success_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_success_r) |-> (out_status_r == dvst_pkg::ST_OK))
    else $error("success reported with non-ok status");

  a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_EXEC) && out_free)
    else $error("RAM write outside write-back");

  a_valid_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(valid_r) <= $past($countones(valid_r)) + 1))
    else $error("more than one slot allocated per request");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result presented without write-back cycle");

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for distinct_value_set_table_top. Requests go in on the
// in_* channel with random gaps, results come back on out_* under random
// back-pressure. A local copy of the table predicts success and status for
// each accepted request, and every result is compared against it in order.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic              success;
    dvst_pkg::status_t status;
  } outcome_t;

  localparam int POOL_SIZE = 24;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic [1:0]        in_kind      = dvst_pkg::KIND_INSERT;
  logic [31:0]       in_value     = '0;
  logic [31:0]       in_new_value = '0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic              out_success;
  logic [2:0]        out_status;

  logic [31:0]       table_vals [dvst_pkg::CAPACITY];
  bit                table_used [dvst_pkg::CAPACITY];
  outcome_t          pending_outcomes [$];
  logic [31:0]       value_pool [POOL_SIZE];

  bit                quiet;
  int                err_count;
  int                sent_count;
  int                checked_count;
  int                status_seen [5];
  int                stall_left;
  int                rx_roll;

  distinct_value_set_table_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_value    (in_value),
    .in_new_value(in_new_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_success (out_success),
    .out_status  (out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("distinct_value_set_table_top test failed");
    $finish;
  end

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Applies one request to the local table and returns the expected outcome.
  function automatic outcome_t table_apply(input dvst_pkg::kind_t k, input logic [31:0] v,
                                           input logic [31:0] nv);
    outcome_t res;
    int hit;
    int free_idx;
    int new_hit;
    hit      = -1;
    free_idx = -1;
    new_hit  = -1;
    for (int i = 0; i < dvst_pkg::CAPACITY; i++) begin
      if (table_used[i] && table_vals[i] == v && hit < 0) hit = i;
      if (table_used[i] && table_vals[i] == nv && new_hit < 0) new_hit = i;
      if (!table_used[i] && free_idx < 0) free_idx = i;
    end
    res.success = 1'b0;
    res.status  = dvst_pkg::ST_NOT_FOUND;
    case (k)
      dvst_pkg::KIND_INSERT: begin
        if (hit >= 0) begin
          res.status = dvst_pkg::ST_PRESENT;
        end else if (free_idx < 0) begin
          res.status = dvst_pkg::ST_FULL;
        end else begin
          table_vals[free_idx] = v;
          table_used[free_idx] = 1'b1;
          res.success = 1'b1;
          res.status  = dvst_pkg::ST_OK;
        end
      end
      dvst_pkg::KIND_REMOVE: begin
        if (hit >= 0) begin
          table_used[hit] = 1'b0;
          res.success = 1'b1;
          res.status  = dvst_pkg::ST_OK;
        end
      end
      dvst_pkg::KIND_REPLACE: begin
        if (hit >= 0) begin
          if (new_hit >= 0) begin
            res.status = dvst_pkg::ST_NEW_PRESENT;
          end else begin
            table_vals[hit] = nv;
            res.success = 1'b1;
            res.status  = dvst_pkg::ST_OK;
          end
        end
      end
      default: begin
        if (hit >= 0) begin
          res.success = 1'b1;
          res.status  = dvst_pkg::ST_OK;
        end
      end
    endcase
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 88) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  task automatic send_request(input dvst_pkg::kind_t k, input logic [31:0] v,
                              input logic [31:0] nv);
    int gap;
    outcome_t res;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= k;
    in_value     <= v;
    in_new_value <= nv;
    do @(posedge clk); while (!in_ready);
    res = table_apply(k, v, nv);
    pending_outcomes.push_back(res);
    status_seen[res.status]++;
    sent_count++;
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        report("result transaction with no request outstanding");
      end else begin
        outcome_t exp_res;
        exp_res = pending_outcomes.pop_front();
        if (out_success !== exp_res.success)
          report($sformatf("result %0d: success %b, expected %b",
                           checked_count, out_success, exp_res.success));
        if (out_status !== exp_res.status)
          report($sformatf("result %0d: status %0d, expected %0d",
                           checked_count, out_status, exp_res.status));
        checked_count++;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (quiet) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 70) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(4, 39);
        out_ready <= 1'b0;
      end
    end
  end

  task automatic test_empty_table();
    send_request(dvst_pkg::KIND_LOOKUP,  32'h0000_0005, 32'h0);
    send_request(dvst_pkg::KIND_REMOVE,  32'h0000_0005, 32'h0);
    send_request(dvst_pkg::KIND_REPLACE, 32'h0000_0005, 32'h0000_0006);
  endtask

  task automatic test_basic_ops();
    send_request(dvst_pkg::KIND_INSERT,  32'h8000_0000, 32'hFFFF_FFFF);
    send_request(dvst_pkg::KIND_INSERT,  32'h7FFF_FFFF, 32'h0);
    send_request(dvst_pkg::KIND_INSERT,  32'h0000_0000, 32'h0);
    send_request(dvst_pkg::KIND_INSERT,  32'hFFFF_FFFF, 32'h8000_0000);
    send_request(dvst_pkg::KIND_INSERT,  32'h0000_0000, 32'h0);
    send_request(dvst_pkg::KIND_LOOKUP,  32'h7FFF_FFFF, 32'h0);
    send_request(dvst_pkg::KIND_LOOKUP,  32'h7FFF_FFFE, 32'h0);
    send_request(dvst_pkg::KIND_REPLACE, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(dvst_pkg::KIND_REPLACE, 32'h0000_0000, 32'h0000_0000);
    send_request(dvst_pkg::KIND_REPLACE, 32'h0000_0000, 32'h5555_5555);
    send_request(dvst_pkg::KIND_REMOVE,  32'hFFFF_FFFF, 32'h0);
    send_request(dvst_pkg::KIND_REMOVE,  32'hFFFF_FFFF, 32'h0);
    send_request(dvst_pkg::KIND_REPLACE, 32'hAAAA_AAAA, 32'h1234_5678);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < dvst_pkg::CAPACITY - 3; i++)
      send_request(dvst_pkg::KIND_INSERT, 32'h1000_0000 + i, 32'h0);
    send_request(dvst_pkg::KIND_INSERT, 32'hDEAD_BEEF, 32'h0);
    send_request(dvst_pkg::KIND_INSERT, 32'h7FFF_FFFF, 32'h0);
  endtask

  task automatic test_random_traffic(input int count, input int ins_pct, input int rem_pct,
                                     input int rep_pct);
    int roll;
    dvst_pkg::kind_t k;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct)                          k = dvst_pkg::KIND_INSERT;
      else if (roll < ins_pct + rem_pct)           k = dvst_pkg::KIND_REMOVE;
      else if (roll < ins_pct + rem_pct + rep_pct) k = dvst_pkg::KIND_REPLACE;
      else                                         k = dvst_pkg::KIND_LOOKUP;
      send_request(k, pick_value(), pick_value());
    end
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    test_random_traffic(150, 35, 25, 25);
    quiet = 1'b0;
  endtask

  initial begin
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    value_pool[4] = 32'h5555_5555;
    for (int i = 0; i < dvst_pkg::CAPACITY - 3; i++) value_pool[5 + i] = 32'h1000_0000 + i;
    for (int i = dvst_pkg::CAPACITY + 2; i < POOL_SIZE; i++) value_pool[i] = $urandom();
    for (int i = 0; i < dvst_pkg::CAPACITY; i++) table_used[i] = 1'b0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_basic_ops();
    test_full_table();
    test_random_traffic(200, 30, 25, 25);
    test_random_traffic(150, 15, 50, 20);
    test_random_traffic(200, 55, 10, 15);
    test_back_to_back();
    test_random_traffic(170, 40, 20, 25);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (2 * dvst_pkg::CAPACITY + 8) @(posedge clk);

    $display("Summary: %0d requests sent, %0d results compared", sent_count, checked_count);
    $display("Statuses: ok %0d, present %0d, not found %0d, full %0d, new present %0d",
             status_seen[dvst_pkg::ST_OK], status_seen[dvst_pkg::ST_PRESENT],
             status_seen[dvst_pkg::ST_NOT_FOUND], status_seen[dvst_pkg::ST_FULL],
             status_seen[dvst_pkg::ST_NEW_PRESENT]);
    if (err_count == 0) begin
      $display("distinct_value_set_table_top test passed");
    end else begin
      $display("distinct_value_set_table_top test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/dvst_pkg.sv
rtl/core/distinct_value_set_table_top.sv
tb/testbench.sv
